// ===== src/iprt_pkg.sv =====
// Package of the IPv4 fragment reassembly tracker.
// Holds item kinds, result codes, datapath operations and the control structs.
// Depends on nothing.
package iprt_pkg;

    localparam logic [1:0] KIND_FRAG = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    localparam logic [2:0] ST_STORED = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_NOT_FRAG = 3'd2;
    localparam logic [2:0] ST_NO_FREE = 3'd3;
    localparam logic [2:0] ST_LIST_FULL = 3'd4;
    localparam logic [2:0] ST_RELEASED = 3'd5;
    localparam logic [2:0] ST_NOT_FOUND = 3'd6;
    localparam logic [2:0] ST_TICK_DONE = 3'd7;

    localparam int MF_BIT = 13;
    localparam int OFF_W = 13;
    localparam logic [15:0] TIMEOUT_RESET = 16'd60;

    typedef logic [4:0] op_t;

    localparam op_t OP_NONE = 5'd0;
    localparam op_t OP_LOAD = 5'd1;
    localparam op_t OP_KEY_RD = 5'd2;
    localparam op_t OP_KEY_CMP = 5'd3;
    localparam op_t OP_ALLOC = 5'd4;
    localparam op_t OP_LIST_RD = 5'd5;
    localparam op_t OP_LIST_CMP = 5'd6;
    localparam op_t OP_MARK = 5'd7;
    localparam op_t OP_SHIFT_RD = 5'd8;
    localparam op_t OP_SHIFT_WR = 5'd9;
    localparam op_t OP_INSERT = 5'd10;
    localparam op_t OP_CPL_INIT = 5'd11;
    localparam op_t OP_CPL_STEP = 5'd12;
    localparam op_t OP_SUM_INIT = 5'd13;
    localparam op_t OP_SUM_STEP = 5'd14;
    localparam op_t OP_FREE = 5'd15;
    localparam op_t OP_TICK_INIT = 5'd16;
    localparam op_t OP_AGE = 5'd17;
    localparam op_t OP_RESULT = 5'd18;

    typedef struct packed {
        op_t        op;
        logic [2:0] res;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       fo_zero;
        logic       match_now;
        logic       idx_last;
        logic       hit;
        logic       free_found;
        logic       k_lt_n;
        logic       scan_stop;
        logic       dup;
        logic       full;
        logic       k_gt_pos;
        logic       ok;
        logic       out_busy;
    } stat_t;

endpackage

// ===== src/iprt_if.sv =====
// Handshake channels of the IPv4 fragment reassembly tracker.
// Input item, result item and configuration write channels; no dependencies.
interface iprt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] ident;
    logic [15:0] flags_offset;
    logic [15:0] body_length;

    modport source (output valid, kind, src_addr, dst_addr, ident, flags_offset, body_length,
                    input ready);
    modport sink (input valid, kind, src_addr, dst_addr, ident, flags_offset, body_length,
                  output ready);
endinterface

interface iprt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        complete;
    logic [15:0] total_length;
    logic [6:0]  purged_count;

    modport source (output valid, status, complete, total_length, purged_count, input ready);
    modport sink (input valid, status, complete, total_length, purged_count, output ready);
endinterface

interface iprt_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== src/iprt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module iprt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/iprt_ctrl.sv =====
// Controller of the IPv4 fragment reassembly tracker.
// Sequences the datapath operations for each item; uses iprt_pkg.
module iprt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  iprt_pkg::stat_t stat,
    output iprt_pkg::cmd_t  cmd
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DECODE = 5'd1;
    localparam logic [4:0] S_SRD = 5'd2;
    localparam logic [4:0] S_SCMP = 5'd3;
    localparam logic [4:0] S_SDONE = 5'd4;
    localparam logic [4:0] S_LCHK = 5'd5;
    localparam logic [4:0] S_LRD = 5'd6;
    localparam logic [4:0] S_LCMP = 5'd7;
    localparam logic [4:0] S_LDEC = 5'd8;
    localparam logic [4:0] S_SHCHK = 5'd9;
    localparam logic [4:0] S_SHRD = 5'd10;
    localparam logic [4:0] S_SHWR = 5'd11;
    localparam logic [4:0] S_CINIT = 5'd12;
    localparam logic [4:0] S_CCHK = 5'd13;
    localparam logic [4:0] S_CRD = 5'd14;
    localparam logic [4:0] S_CSTEP = 5'd15;
    localparam logic [4:0] S_SUMCHK = 5'd16;
    localparam logic [4:0] S_SURD = 5'd17;
    localparam logic [4:0] S_SUSTEP = 5'd18;
    localparam logic [4:0] S_TRD = 5'd19;
    localparam logic [4:0] S_TAGE = 5'd20;
    localparam logic [4:0] S_RES = 5'd21;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic [2:0] res_reg;
    logic [2:0] res_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        res_next = res_reg;
        cmd.op = iprt_pkg::OP_NONE;
        cmd.res = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = iprt_pkg::OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.kind)
                    iprt_pkg::KIND_FRAG:
                    begin
                        if (stat.fo_zero)
                        begin
                            res_next = iprt_pkg::ST_NOT_FRAG;
                            state_next = S_RES;
                        end
                        else
                        begin
                            state_next = S_SRD;
                        end
                    end
                    iprt_pkg::KIND_RELEASE:
                    begin
                        state_next = S_SRD;
                    end
                    iprt_pkg::KIND_TICK:
                    begin
                        cmd.op = iprt_pkg::OP_TICK_INIT;
                        state_next = S_TRD;
                    end
                    default:
                    begin
                        res_next = iprt_pkg::ST_NOT_FOUND;
                        state_next = S_RES;
                    end
                endcase
            end
            S_SRD:
            begin
                cmd.op = iprt_pkg::OP_KEY_RD;
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                cmd.op = iprt_pkg::OP_KEY_CMP;
                state_next = (stat.match_now || stat.idx_last) ? S_SDONE : S_SRD;
            end
            S_SDONE:
            begin
                if (stat.kind == iprt_pkg::KIND_FRAG)
                begin
                    if (stat.hit || stat.free_found)
                    begin
                        cmd.op = iprt_pkg::OP_ALLOC;
                        state_next = S_LCHK;
                    end
                    else
                    begin
                        res_next = iprt_pkg::ST_NO_FREE;
                        state_next = S_RES;
                    end
                end
                else if (stat.hit)
                begin
                    cmd.op = iprt_pkg::OP_SUM_INIT;
                    state_next = S_SUMCHK;
                end
                else
                begin
                    res_next = iprt_pkg::ST_NOT_FOUND;
                    state_next = S_RES;
                end
            end
            S_LCHK:
            begin
                state_next = (stat.k_lt_n && !stat.scan_stop) ? S_LRD : S_LDEC;
            end
            S_LRD:
            begin
                cmd.op = iprt_pkg::OP_LIST_RD;
                state_next = S_LCMP;
            end
            S_LCMP:
            begin
                cmd.op = iprt_pkg::OP_LIST_CMP;
                state_next = S_LCHK;
            end
            S_LDEC:
            begin
                if (!stat.dup && stat.full)
                begin
                    res_next = iprt_pkg::ST_LIST_FULL;
                    state_next = S_CINIT;
                end
                else
                begin
                    cmd.op = iprt_pkg::OP_MARK;
                    if (stat.dup)
                    begin
                        res_next = iprt_pkg::ST_DUPLICATE;
                        state_next = S_CINIT;
                    end
                    else
                    begin
                        res_next = iprt_pkg::ST_STORED;
                        state_next = S_SHCHK;
                    end
                end
            end
            S_SHCHK:
            begin
                if (stat.k_gt_pos)
                begin
                    state_next = S_SHRD;
                end
                else
                begin
                    cmd.op = iprt_pkg::OP_INSERT;
                    state_next = S_CINIT;
                end
            end
            S_SHRD:
            begin
                cmd.op = iprt_pkg::OP_SHIFT_RD;
                state_next = S_SHWR;
            end
            S_SHWR:
            begin
                cmd.op = iprt_pkg::OP_SHIFT_WR;
                state_next = S_SHCHK;
            end
            S_CINIT:
            begin
                cmd.op = iprt_pkg::OP_CPL_INIT;
                state_next = S_CCHK;
            end
            S_CCHK:
            begin
                state_next = (stat.k_lt_n && stat.ok) ? S_CRD : S_RES;
            end
            S_CRD:
            begin
                cmd.op = iprt_pkg::OP_LIST_RD;
                state_next = S_CSTEP;
            end
            S_CSTEP:
            begin
                cmd.op = iprt_pkg::OP_CPL_STEP;
                state_next = S_CCHK;
            end
            S_SUMCHK:
            begin
                if (stat.k_lt_n)
                begin
                    state_next = S_SURD;
                end
                else
                begin
                    cmd.op = iprt_pkg::OP_FREE;
                    res_next = iprt_pkg::ST_RELEASED;
                    state_next = S_RES;
                end
            end
            S_SURD:
            begin
                cmd.op = iprt_pkg::OP_LIST_RD;
                state_next = S_SUSTEP;
            end
            S_SUSTEP:
            begin
                cmd.op = iprt_pkg::OP_SUM_STEP;
                state_next = S_SUMCHK;
            end
            S_TRD:
            begin
                cmd.op = iprt_pkg::OP_KEY_RD;
                state_next = S_TAGE;
            end
            S_TAGE:
            begin
                cmd.op = iprt_pkg::OP_AGE;
                if (stat.idx_last)
                begin
                    res_next = iprt_pkg::ST_TICK_DONE;
                    state_next = S_RES;
                end
                else
                begin
                    state_next = S_TRD;
                end
            end
            S_RES:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op = iprt_pkg::OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg <= iprt_pkg::ST_NOT_FOUND;
        end
        else
        begin
            state_reg <= state_next;
            res_reg <= res_next;
        end
    end

endmodule

// ===== src/iprt_dp.sv =====
// Datapath of the IPv4 fragment reassembly tracker.
// Entry flags, key, time-stamp and fragment memories, counters and the result
// register; uses iprt_pkg, iprt_if and iprt_ram.
module iprt_dp #(
    parameter int NUM_DATAGRAMS = 8,
    parameter int MAX_FRAGMENTS = 8,
    parameter int HEADER_BYTES = 20
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_ready,
    iprt_in_if.sink         in_ch,
    iprt_out_if.source      out_ch,
    iprt_cfg_if.sink        cfg,
    input  iprt_pkg::cmd_t  cmd,
    output iprt_pkg::stat_t stat
);

    localparam int EW = (NUM_DATAGRAMS > 1) ? $clog2(NUM_DATAGRAMS) : 1;
    localparam int KW = $clog2(MAX_FRAGMENTS + 1);
    localparam int SLOTS = NUM_DATAGRAMS * MAX_FRAGMENTS;
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SW = 16 + KW + 1;
    localparam int KEY_W = 80;
    localparam int FRAG_W = iprt_pkg::OFF_W + 16;

    logic [1:0]  kind_reg;
    logic [31:0] src_reg;
    logic [31:0] dst_reg;
    logic [15:0] ident_reg;
    logic [15:0] fo_reg;
    logic [15:0] len_reg;
    logic [15:0] timeout_reg;
    logic [31:0] now_reg;

    logic          valid_reg [NUM_DATAGRAMS];
    logic          end_reg [NUM_DATAGRAMS];
    logic [KW-1:0] count_reg [NUM_DATAGRAMS];

    logic [EW-1:0] idx_reg;
    logic [EW-1:0] hit_idx_reg;
    logic [EW-1:0] free_idx_reg;
    logic [EW-1:0] e_reg;
    logic          hit_reg;
    logic          free_reg;
    logic [KW-1:0] k_reg;
    logic [KW-1:0] pos_reg;
    logic          dup_reg;
    logic          stop_reg;
    logic          ok_reg;
    logic [SW-1:0] acc_reg;
    logic [6:0]    purged_reg;

    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic        out_complete_reg;
    logic [15:0] out_total_reg;
    logic [6:0]  out_purged_reg;

    logic              key_we;
    logic [KEY_W-1:0]  key_rdata;
    logic              key_re;
    logic              ls_we;
    logic [31:0]       ls_rdata;
    logic              frag_we;
    logic [AW-1:0]     frag_waddr;
    logic [FRAG_W-1:0] frag_wdata;
    logic              frag_re;
    logic [AW-1:0]     frag_raddr;
    logic [FRAG_W-1:0] frag_rdata;

    logic [KW-1:0]            count_cur;
    logic                     match_now;
    logic                     idx_last;
    logic [iprt_pkg::OFF_W-1:0] off_in;
    logic [iprt_pkg::OFF_W-1:0] off_st;
    logic [15:0]              len_st;
    logic [EW-1:0]            alloc_idx;
    int                       base;
    logic [31:0]              age;

    assign count_cur = count_reg[e_reg];
    assign idx_last = (idx_reg == EW'(NUM_DATAGRAMS - 1));
    assign match_now = valid_reg[idx_reg] && (key_rdata == {src_reg, dst_reg, ident_reg});
    assign off_in = fo_reg[iprt_pkg::OFF_W-1:0];
    assign off_st = frag_rdata[FRAG_W-1:16];
    assign len_st = frag_rdata[15:0];
    assign alloc_idx = hit_reg ? hit_idx_reg : free_idx_reg;
    assign base = int'(e_reg) * MAX_FRAGMENTS;
    assign age = now_reg - ls_rdata;

    assign key_we = (cmd.op == iprt_pkg::OP_ALLOC) && !hit_reg;
    assign key_re = (cmd.op == iprt_pkg::OP_KEY_RD);
    assign ls_we = (cmd.op == iprt_pkg::OP_MARK);
    assign frag_re = (cmd.op == iprt_pkg::OP_LIST_RD) || (cmd.op == iprt_pkg::OP_SHIFT_RD);
    assign frag_raddr = (cmd.op == iprt_pkg::OP_SHIFT_RD) ? AW'(base + int'(k_reg) - 1)
                                                          : AW'(base + int'(k_reg));
    assign frag_we = (cmd.op == iprt_pkg::OP_SHIFT_WR) || (cmd.op == iprt_pkg::OP_INSERT);
    assign frag_waddr = (cmd.op == iprt_pkg::OP_SHIFT_WR) ? AW'(base + int'(k_reg))
                                                          : AW'(base + int'(pos_reg));
    assign frag_wdata = (cmd.op == iprt_pkg::OP_SHIFT_WR) ? frag_rdata : {off_in, len_reg};

    iprt_ram #(.WIDTH(KEY_W), .DEPTH(NUM_DATAGRAMS)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (alloc_idx),
        .wdata ({src_reg, dst_reg, ident_reg}),
        .re    (key_re),
        .raddr (idx_reg),
        .rdata (key_rdata)
    );

    iprt_ram #(.WIDTH(32), .DEPTH(NUM_DATAGRAMS)) u_ls_ram (
        .clk   (clk),
        .we    (ls_we),
        .waddr (e_reg),
        .wdata (now_reg),
        .re    (key_re),
        .raddr (idx_reg),
        .rdata (ls_rdata)
    );

    iprt_ram #(.WIDTH(FRAG_W), .DEPTH(SLOTS)) u_frag_ram (
        .clk   (clk),
        .we    (frag_we),
        .waddr (frag_waddr),
        .wdata (frag_wdata),
        .re    (frag_re),
        .raddr (frag_raddr),
        .rdata (frag_rdata)
    );

    assign in_ch.ready = in_ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        stat.kind = kind_reg;
        stat.fo_zero = (fo_reg == 16'd0);
        stat.match_now = match_now;
        stat.idx_last = idx_last;
        stat.hit = hit_reg;
        stat.free_found = free_reg;
        stat.k_lt_n = (k_reg < count_cur);
        stat.scan_stop = stop_reg;
        stat.dup = dup_reg;
        stat.full = (count_cur >= KW'(MAX_FRAGMENTS));
        stat.k_gt_pos = (k_reg > pos_reg);
        stat.ok = ok_reg;
        stat.out_busy = out_valid_reg && !out_ch.ready;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.status = out_status_reg;
    assign out_ch.complete = out_complete_reg;
    assign out_ch.total_length = out_total_reg;
    assign out_ch.purged_count = out_purged_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= iprt_pkg::TIMEOUT_RESET;
            now_reg <= 32'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_DATAGRAMS; i++)
            begin
                valid_reg[i] <= 1'b0;
                end_reg[i] <= 1'b0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg.valid)
            begin
                timeout_reg <= cfg.data;
            end
            if (cmd.op == iprt_pkg::OP_RESULT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                iprt_pkg::OP_ALLOC:
                begin
                    if (!hit_reg)
                    begin
                        valid_reg[alloc_idx] <= 1'b1;
                        end_reg[alloc_idx] <= 1'b0;
                        count_reg[alloc_idx] <= '0;
                    end
                end
                iprt_pkg::OP_MARK:
                begin
                    if (!fo_reg[iprt_pkg::MF_BIT])
                    begin
                        end_reg[e_reg] <= 1'b1;
                    end
                end
                iprt_pkg::OP_INSERT:
                begin
                    count_reg[e_reg] <= count_cur + KW'(1);
                end
                iprt_pkg::OP_FREE:
                begin
                    valid_reg[e_reg] <= 1'b0;
                    end_reg[e_reg] <= 1'b0;
                    count_reg[e_reg] <= '0;
                end
                iprt_pkg::OP_TICK_INIT:
                begin
                    now_reg <= now_reg + 32'd1;
                end
                iprt_pkg::OP_AGE:
                begin
                    if (valid_reg[idx_reg] && (age > {16'd0, timeout_reg}))
                    begin
                        valid_reg[idx_reg] <= 1'b0;
                        end_reg[idx_reg] <= 1'b0;
                        count_reg[idx_reg] <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            iprt_pkg::OP_LOAD:
            begin
                kind_reg <= in_ch.kind;
                src_reg <= in_ch.src_addr;
                dst_reg <= in_ch.dst_addr;
                ident_reg <= in_ch.ident;
                fo_reg <= in_ch.flags_offset;
                len_reg <= in_ch.body_length;
                idx_reg <= '0;
                hit_reg <= 1'b0;
                free_reg <= 1'b0;
                ok_reg <= 1'b0;
            end
            iprt_pkg::OP_KEY_CMP:
            begin
                if (match_now && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                    hit_idx_reg <= idx_reg;
                end
                if (!valid_reg[idx_reg] && !free_reg)
                begin
                    free_reg <= 1'b1;
                    free_idx_reg <= idx_reg;
                end
                if (!idx_last)
                begin
                    idx_reg <= idx_reg + EW'(1);
                end
            end
            iprt_pkg::OP_ALLOC:
            begin
                e_reg <= alloc_idx;
                pos_reg <= hit_reg ? count_reg[hit_idx_reg] : '0;
                k_reg <= '0;
                dup_reg <= 1'b0;
                stop_reg <= 1'b0;
            end
            iprt_pkg::OP_LIST_CMP:
            begin
                if (off_st == off_in)
                begin
                    dup_reg <= 1'b1;
                    stop_reg <= 1'b1;
                end
                else if (off_in < off_st)
                begin
                    pos_reg <= k_reg;
                    stop_reg <= 1'b1;
                end
                else
                begin
                    k_reg <= k_reg + KW'(1);
                end
            end
            iprt_pkg::OP_MARK:
            begin
                k_reg <= count_cur;
            end
            iprt_pkg::OP_SHIFT_WR:
            begin
                k_reg <= k_reg - KW'(1);
            end
            iprt_pkg::OP_CPL_INIT:
            begin
                k_reg <= '0;
                acc_reg <= '0;
                ok_reg <= end_reg[e_reg];
            end
            iprt_pkg::OP_CPL_STEP:
            begin
                if (SW'({off_st, 3'b000}) != acc_reg)
                begin
                    ok_reg <= 1'b0;
                end
                acc_reg <= acc_reg + SW'(len_st);
                k_reg <= k_reg + KW'(1);
            end
            iprt_pkg::OP_SUM_INIT:
            begin
                e_reg <= hit_idx_reg;
                k_reg <= '0;
                acc_reg <= SW'(HEADER_BYTES);
            end
            iprt_pkg::OP_SUM_STEP:
            begin
                acc_reg <= acc_reg + SW'(len_st);
                k_reg <= k_reg + KW'(1);
            end
            iprt_pkg::OP_TICK_INIT:
            begin
                idx_reg <= '0;
                purged_reg <= '0;
            end
            iprt_pkg::OP_AGE:
            begin
                if (valid_reg[idx_reg] && (age > {16'd0, timeout_reg}))
                begin
                    purged_reg <= purged_reg + 7'd1;
                end
                if (!idx_last)
                begin
                    idx_reg <= idx_reg + EW'(1);
                end
            end
            iprt_pkg::OP_RESULT:
            begin
                out_status_reg <= cmd.res;
                out_complete_reg <= ((cmd.res == iprt_pkg::ST_STORED)
                                     || (cmd.res == iprt_pkg::ST_DUPLICATE)
                                     || (cmd.res == iprt_pkg::ST_LIST_FULL)) && ok_reg;
                if (cmd.res == iprt_pkg::ST_RELEASED)
                begin
                    out_total_reg <= (acc_reg > SW'(16'hFFFF)) ? 16'hFFFF : acc_reg[15:0];
                end
                else
                begin
                    out_total_reg <= 16'd0;
                end
                out_purged_reg <= (cmd.res == iprt_pkg::ST_TICK_DONE) ? purged_reg : 7'd0;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== src/ipv4_fragment_reassembly_tracker.sv =====
// Top level of the IPv4 fragment reassembly tracker.
// Joins iprt_ctrl and iprt_dp; uses iprt_pkg and the channels of iprt_if.
//
// Items are taken one at a time. Every item is taken and then decoded. A
// fragment item then searches the datagram table entry by entry, scans the
// entry's stored fragments for the insertion point, moves the slots behind it
// up by one and walks the fragment list to check completeness. A release
// takes the search and then sums the lengths of its fragments; a tick ages
// every entry of the table, and a zero flags/offset field or an unused kind
// goes straight to the result. Each step waits for one registered memory
// read. A finished result waits in an output register, so the next item is
// taken while it is pending; that item stalls in its result state until the
// register has drained.
module ipv4_fragment_reassembly_tracker #(
    parameter int NUM_DATAGRAMS = 8,
    parameter int MAX_FRAGMENTS = 8,
    parameter int HEADER_BYTES = 20
) (
    input logic        clk,
    input logic        rst_n,
    iprt_in_if.sink    frag_in,
    iprt_out_if.source result_out,
    iprt_cfg_if.sink   cfg
);

    iprt_pkg::cmd_t  cmd;
    iprt_pkg::stat_t stat;
    logic            in_ready;

    iprt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (frag_in.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    iprt_dp #(
        .NUM_DATAGRAMS (NUM_DATAGRAMS),
        .MAX_FRAGMENTS (MAX_FRAGMENTS),
        .HEADER_BYTES  (HEADER_BYTES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ready (in_ready),
        .in_ch    (frag_in),
        .out_ch   (result_out),
        .cfg      (cfg),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
